/* design/scam_pkg.sv */
// shared types and constants for the session cam
package scam_pkg;

  localparam int SESSION_BITS   = 14;
  localparam int REQUESTER_BITS = 1;
  localparam int KEY_BITS       = 96;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  typedef struct packed {
    logic [1:0]                cmd;
    logic [31:0]               their_ip;
    logic [15:0]               their_port;
    logic [31:0]               my_ip;
    logic [15:0]               my_port;
    logic [SESSION_BITS-1:0]   session_id;
    logic [REQUESTER_BITS-1:0] requester;
  } req_t;

  typedef struct packed {
    logic [1:0]                reply_kind;
    logic                      hit;
    logic [SESSION_BITS-1:0]   session_out;
    logic [REQUESTER_BITS-1:0] requester_out;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load_req;
    logic commit;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage

/* design/scam_ctrl.sv */
// request sequencer for the session cam
module scam_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  scam_pkg::dp_status_t  status,
  output scam_pkg::ctl_cmd_t    cmd
);

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_EXEC = 1'b1;

  logic [0:0] state_r;
  logic [0:0] state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // wait while the previous reply is still held
        if (!status.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* design/scam_dp.sv */
// entry storage, parallel key compare and reply register for the session cam
module scam_dp #(
  parameter int ENTRIES = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  scam_pkg::req_t       in_data,
  input  scam_pkg::ctl_cmd_t   cmd,
  output scam_pkg::dp_status_t status,
  output logic                 out_valid,
  output scam_pkg::rsp_t       out_data,
  input  logic                 out_stall
);

  scam_pkg::req_t req_r;

  logic [ENTRIES-1:0]                    valid_r;
  logic [ENTRIES-1:0]                    valid_nxt;
  logic [scam_pkg::KEY_BITS-1:0]         key_r   [ENTRIES];
  logic [scam_pkg::SESSION_BITS-1:0]     value_r [ENTRIES];

  logic [scam_pkg::KEY_BITS-1:0]         req_key;
  logic [ENTRIES-1:0]                    match_vec;
  logic [ENTRIES-1:0]                    match_oh;
  logic [ENTRIES-1:0]                    free_vec;
  logic [ENTRIES-1:0]                    free_oh;
  logic [scam_pkg::SESSION_BITS-1:0]     found_value;
  logic                                  found;

  logic           out_valid_r;
  logic           out_valid_nxt;
  scam_pkg::rsp_t out_data_r;
  scam_pkg::rsp_t rsp;

  assign req_key = {req_r.my_ip, req_r.their_ip, req_r.my_port, req_r.their_port};

  // one compare per entry
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_vec[i] = valid_r[i] && (key_r[i] == req_key);
    end
  end

  assign free_vec = ~valid_r;
  // isolate lowest set bit
  assign match_oh = match_vec & (~match_vec + {{(ENTRIES-1){1'b0}}, 1'b1});
  assign free_oh  = free_vec & (~free_vec + {{(ENTRIES-1){1'b0}}, 1'b1});
  assign found    = |match_vec;

  always_comb begin
    found_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      found_value = found_value | (value_r[i] & {scam_pkg::SESSION_BITS{match_oh[i]}});
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (cmd.commit) begin
      if (req_r.cmd == scam_pkg::CMD_INSERT) begin
        valid_nxt = valid_r | free_oh;
      end else if (req_r.cmd == scam_pkg::CMD_DELETE) begin
        valid_nxt = valid_r & ~match_oh;
      end
    end
  end

  always_comb begin
    rsp.reply_kind    = req_r.cmd;
    rsp.hit           = 1'b0;
    rsp.session_out   = req_r.session_id;
    rsp.requester_out = req_r.requester;
    if (req_r.cmd == scam_pkg::CMD_LOOKUP) begin
      rsp.hit         = found;
      rsp.session_out = found_value;
    end
  end

  assign status.out_busy = out_valid_r && out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit && (req_r.cmd != scam_pkg::CMD_NONE)) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= in_data;
    end
    if (cmd.commit && (req_r.cmd != scam_pkg::CMD_NONE)) begin
      out_data_r <= rsp;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (cmd.commit && (req_r.cmd == scam_pkg::CMD_INSERT) && free_oh[i]) begin
        key_r[i]   <= req_key;
        value_r[i] <= req_r.session_id;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* design/session_cam_lookup_insert_delete.sv */
// top level of the session cam: lookup, insert and delete of socket four-tuples
// reply: the request is captured in the request register, and its reply is registered
//   when exec resolves it, which waits while the previous reply is stalled at the output
// sequencing: a new request is taken only after the previous one is resolved
// reset: synchronous active-low rst_n clears all entry valid bits, the sequencer
//   and the reply valid; stored keys and values are not cleared
module session_cam_lookup_insert_delete #(
  parameter int ENTRIES = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  // request channel
  input  logic           in_valid,
  input  scam_pkg::req_t in_data,
  output logic           in_stall,
  // reply channel
  output logic           out_valid,
  output scam_pkg::rsp_t out_data,
  input  logic           out_stall
);

  // command and status between sequencer and datapath
  scam_pkg::ctl_cmd_t   ctl_cmd;
  scam_pkg::dp_status_t dp_status;

  // sequencer: idle takes a request, exec resolves it once the reply slot is free
  scam_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (dp_status),
    .cmd      (ctl_cmd)
  );

  // datapath: request register, per-entry compare lanes, lowest-match and
  // lowest-free pick, reply register
  scam_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (ctl_cmd),
    .status    (dp_status),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  // a taken request blocks the next one in the cycle after it is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request taken back to back");

  // a request is never captured in the same cycle another is resolved
  assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl_cmd.load_req && ctl_cmd.commit))
    else $error("capture and resolve overlap");

  // resolving never overwrites a reply that is still held
  assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.commit |-> !(out_valid && out_stall))
    else $error("held reply overwritten");

endmodule

/* test/session_cam_lookup_insert_delete_tb.sv */
// self-checking testbench for the session cam lookup, insert and delete block
module session_cam_lookup_insert_delete_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          ENTRIES     = 8;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_REPORTS = 10;

  typedef logic [scam_pkg::SESSION_BITS-1:0]   session_t;
  typedef logic [scam_pkg::REQUESTER_BITS-1:0] requester_t;

  // socket four-tuple, the match key of one cam entry
  typedef struct packed {
    logic [31:0] their_ip;
    logic [15:0] their_port;
    logic [31:0] my_ip;
    logic [15:0] my_port;
  } tuple_t;

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  scam_pkg::req_t in_data   = '0;
  logic           in_stall;
  logic           out_valid;
  scam_pkg::rsp_t out_data;
  logic           out_stall = 1'b0;

  // shadow copy of the cam contents
  bit       cam_live    [ENTRIES];
  tuple_t   cam_tuple   [ENTRIES];
  session_t cam_session [ENTRIES];

  scam_pkg::rsp_t pending_replies [$];
  scam_pkg::rsp_t want_reply;
  int unsigned    error_count = 0;
  int unsigned    cycle_count = 0;
  int unsigned    stall_left  = 0;
  int unsigned    stall_draw;

  // idling switches, flipped per phase so that some stretches run flat out
  bit driver_idle = 1'b0;
  bit sink_idle   = 1'b0;

  session_cam_lookup_insert_delete #(
    .ENTRIES (ENTRIES)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog on total run length
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding",
               cycle_count, pending_replies.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic void note_failure(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // lowest live entry holding this tuple, ENTRIES when none does
  function automatic int lowest_match(tuple_t key);
    for (int i = 0; i < ENTRIES; i++) begin
      if (cam_live[i] && cam_tuple[i] == key) return i;
    end
    return ENTRIES;
  endfunction

  // expected reply of one request, updating the shadow cam on the way
  function automatic scam_pkg::rsp_t predict_reply(scam_pkg::req_t r);
    scam_pkg::rsp_t rsp;
    tuple_t         key;
    int             slot;
    bit             placed;
    key = {r.their_ip, r.their_port, r.my_ip, r.my_port};
    rsp.reply_kind    = r.cmd;
    rsp.hit           = 1'b0;
    rsp.session_out   = r.session_id;
    rsp.requester_out = r.requester;
    case (r.cmd)
      scam_pkg::CMD_LOOKUP: begin
        slot = lowest_match(key);
        if (slot < ENTRIES) begin
          rsp.hit         = 1'b1;
          rsp.session_out = cam_session[slot];
        end else begin
          rsp.session_out = '0;
        end
      end
      scam_pkg::CMD_INSERT: begin
        // no duplicate check, first free slot wins, dropped when full
        placed = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
          if (!placed && !cam_live[i]) begin
            cam_live[i]    = 1'b1;
            cam_tuple[i]   = key;
            cam_session[i] = r.session_id;
            placed         = 1'b1;
          end
        end
      end
      scam_pkg::CMD_DELETE: begin
        slot = lowest_match(key);
        if (slot < ENTRIES) cam_live[slot] = 1'b0;
      end
      default: ;
    endcase
    return rsp;
  endfunction

  function automatic scam_pkg::req_t make_request(logic [1:0] cmd, tuple_t key,
                                                  session_t session,
                                                  requester_t requester);
    scam_pkg::req_t r;
    r.cmd        = cmd;
    r.their_ip   = key.their_ip;
    r.their_port = key.their_port;
    r.my_ip      = key.my_ip;
    r.my_port    = key.my_port;
    r.session_id = session;
    r.requester  = requester;
    return r;
  endfunction

  function automatic tuple_t random_tuple();
    tuple_t key;
    key.their_ip   = $urandom;
    key.their_port = 16'($urandom_range(0, 65535));
    key.my_ip      = $urandom;
    key.my_port    = 16'($urandom_range(0, 65535));
    return key;
  endfunction

  function automatic session_t random_session();
    return session_t'($urandom_range(0, 16383));
  endfunction

  function automatic requester_t random_requester();
    return requester_t'($urandom_range(0, 1));
  endfunction

  // drives one request, holds it until taken, then records its reply
  // entered and left at a rising edge; valid stays high into the next call
  task automatic send_request(scam_pkg::req_t r);
    int unsigned gap;
    gap = driver_idle ? $urandom_range(0, 10) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    // unused command code is dropped without a reply
    if (r.cmd != scam_pkg::CMD_NONE) pending_replies.push_back(predict_reply(r));
  endtask

  // sink side: a random stall is drawn after every taken reply while sink_idle is set
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end else if (out_valid && !out_stall) begin
      stall_draw = sink_idle ? $urandom_range(0, 10) : 0;
      stall_left <= stall_draw;
      out_stall  <= (stall_draw != 0);
    end
  end

  // reply checker, in order against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        note_failure($sformatf(
          "unexpected reply: kind %0d hit %0d session %0d requester %0d",
          out_data.reply_kind, out_data.hit, out_data.session_out,
          out_data.requester_out));
      end else begin
        want_reply = pending_replies.pop_front();
        if (out_data.reply_kind !== want_reply.reply_kind ||
            out_data.hit !== want_reply.hit ||
            out_data.session_out !== want_reply.session_out ||
            out_data.requester_out !== want_reply.requester_out) begin
          note_failure($sformatf({
            "reply mismatch: expected kind %0d hit %0d session %0d requester %0d, ",
            "got kind %0d hit %0d session %0d requester %0d"},
            want_reply.reply_kind, want_reply.hit, want_reply.session_out,
            want_reply.requester_out, out_data.reply_kind, out_data.hit,
            out_data.session_out, out_data.requester_out));
        end
      end
    end
  end

  // lookups and a delete against an empty table, plus the unused command code
  task automatic test_empty_table();
    send_request(make_request(scam_pkg::CMD_LOOKUP, '0, '1, 1'b0));
    send_request(make_request(scam_pkg::CMD_LOOKUP, '1, 14'h2aaa, 1'b1));
    // delete of a key that is not there still gets its reply
    send_request(make_request(scam_pkg::CMD_DELETE, '1, 14'h1555, 1'b1));
    send_request(make_request(scam_pkg::CMD_NONE, '1, '1, 1'b1));
  endtask

  // all-ones and all-zeros keys with extreme session ids and both requesters
  task automatic test_insert_lookup();
    send_request(make_request(scam_pkg::CMD_INSERT, '1, '1, 1'b1));
    send_request(make_request(scam_pkg::CMD_INSERT, '0, '0, 1'b0));
    send_request(make_request(scam_pkg::CMD_LOOKUP, '1, '0, 1'b0));
    send_request(make_request(scam_pkg::CMD_LOOKUP, '0, '1, 1'b1));
  endtask

  // a single flipped bit in the key must miss
  task automatic test_near_miss();
    tuple_t key;
    key = '1;
    key.their_ip[0] = 1'b0;
    send_request(make_request(scam_pkg::CMD_LOOKUP, key, 14'h0001, 1'b1));
    key = '1;
    key.my_port[15] = 1'b0;
    send_request(make_request(scam_pkg::CMD_LOOKUP, key, 14'h0002, 1'b0));
  endtask

  // duplicate insert: lookups and deletes act on the lowest copy first
  task automatic test_duplicate_keys();
    send_request(make_request(scam_pkg::CMD_INSERT, '1, 14'd5, 1'b0));
    send_request(make_request(scam_pkg::CMD_LOOKUP, '1, 14'd0, 1'b1));
    send_request(make_request(scam_pkg::CMD_DELETE, '1, 14'd77, 1'b0));
    send_request(make_request(scam_pkg::CMD_LOOKUP, '1, 14'd0, 1'b0));
    send_request(make_request(scam_pkg::CMD_DELETE, '1, 14'd78, 1'b1));
    send_request(make_request(scam_pkg::CMD_LOOKUP, '1, 14'd0, 1'b1));
  endtask

  // fill every slot, drop an insert on a full table, then free one and retry
  task automatic test_table_full();
    tuple_t filler [ENTRIES-1];
    tuple_t late_key;
    for (int i = 0; i < ENTRIES - 1; i++) begin
      filler[i] = random_tuple();
      send_request(make_request(scam_pkg::CMD_INSERT, filler[i], random_session(),
                                random_requester()));
    end
    late_key = random_tuple();
    send_request(make_request(scam_pkg::CMD_INSERT, late_key, 14'h3333, 1'b1));
    send_request(make_request(scam_pkg::CMD_LOOKUP, late_key, 14'h0, 1'b0));
    send_request(make_request(scam_pkg::CMD_DELETE, filler[2], 14'h0abc, 1'b0));
    send_request(make_request(scam_pkg::CMD_INSERT, late_key, 14'h3334, 1'b1));
    send_request(make_request(scam_pkg::CMD_LOOKUP, late_key, 14'h0, 1'b1));
  endtask

  // mixed traffic over a small key pool so that hits, duplicates and a full
  // table keep happening; pool and idling modes change every stretch
  task automatic test_random_traffic(int unsigned count);
    tuple_t      key_pool [12];
    tuple_t      key;
    int unsigned sent;
    int unsigned next_refresh;
    int unsigned roll;
    logic [1:0]  cmd;
    sent         = 0;
    next_refresh = 0;
    while (sent < count) begin
      if (sent >= next_refresh) begin
        foreach (key_pool[i]) key_pool[i] = random_tuple();
        driver_idle  = ($urandom_range(0, 3) != 0);
        sink_idle    = ($urandom_range(0, 3) != 0);
        next_refresh = sent + 100;
      end
      roll = $urandom_range(0, 99);
      if (roll < 5)       cmd = scam_pkg::CMD_NONE;
      else if (roll < 45) cmd = scam_pkg::CMD_LOOKUP;
      else if (roll < 75) cmd = scam_pkg::CMD_INSERT;
      else                cmd = scam_pkg::CMD_DELETE;
      // mostly pool keys, some near misses, some fresh noise
      roll = $urandom_range(0, 9);
      key  = key_pool[$urandom_range(0, 11)];
      if (roll == 0)      key = random_tuple();
      else if (roll == 1) key = key ^ (96'b1 << $urandom_range(0, 95));
      send_request(make_request(cmd, key, random_session(), random_requester()));
      if (cmd != scam_pkg::CMD_NONE) sent++;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // reset leaves every entry invalid
    foreach (cam_live[i]) cam_live[i] = 1'b0;

    driver_idle = 1'b0;
    sink_idle   = 1'b0;
    test_empty_table();
    test_insert_lookup();
    driver_idle = 1'b1;
    sink_idle   = 1'b1;
    test_near_miss();
    test_duplicate_keys();
    driver_idle = 1'b0;
    test_table_full();
    test_random_traffic(1300);

    in_valid <= 1'b0;
    // drain, then give a stray reply time to show up
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (pending_replies.size() != 0) note_failure("replies left outstanding at end of run");

    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
